// ----- rtl/ftc_pkg.sv -----
// ----------------------------------------------------------------------------
// ftc_pkg
// Shared types and constants for the filmic tone curve pipeline.
// ----------------------------------------------------------------------------
package ftc_pkg;

    localparam int TOE_STAGES  = 19;
    localparam int CRV_STAGES  = 20;
    localparam int NSTG        = TOE_STAGES + CRV_STAGES;

    localparam logic [1:0] CFG_EXPOSURE_GAIN = 2'd0;
    localparam logic [1:0] CFG_TOE_CUTOFF    = 2'd1;

    localparam logic [15:0] K_MIN = 16'd1;
    localparam logic [15:0] K_MAX = 16'd32768;

    typedef struct packed {
        logic [23:0] red_in;
        logic [23:0] green_in;
        logic [23:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
    } t_pix_out;

    typedef struct packed {
        logic [23:0] gain;
        logic [15:0] k;
    } t_cfg;

    typedef struct packed {
        logic adv;
        logic use_skid;
        logic load_skid;
        logic out_valid;
    } t_ctl;

endpackage

// ----- rtl/ftc_toe.sv -----
// ----------------------------------------------------------------------------
// ftc_toe
// Exposure scale, saturation and black toe blend for one channel.
// ----------------------------------------------------------------------------
module ftc_toe
    import ftc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_cfg        i_cfg,
    input  logic [23:0] i_chan,
    output logic [39:0] o_x
);

    localparam int DIV_STG = TOE_STAGES - 3;

    function automatic logic [79:0] toe_step2(input logic [15:0] rem_in,
                                              input logic [31:0] lo_in,
                                              input logic [31:0] q_in,
                                              input logic [15:0] k);
        logic [16:0] r2;
        logic [15:0] rem;
        logic [31:0] lo;
        logic [31:0] q;
        rem = rem_in;
        lo  = lo_in;
        q   = q_in;
        for (int i = 0; i < 2; i++) begin
            r2 = {rem, lo[31]};
            lo = {lo[30:0], 1'b0};
            if (r2 >= {1'b0, k}) begin
                rem = 16'(r2 - {1'b0, k});
                q   = {q[30:0], 1'b1};
            end else begin
                rem = r2[15:0];
                q   = {q[30:0], 1'b0};
            end
        end
        return {rem, lo, q};
    endfunction

    logic [47:0] w_prod;
    logic [23:0] r_c1;
    logic [25:0] w_ds;
    logic        w_pos;
    logic [33:0] w_dsq;
    logic [32:0] r_dsq;
    logic [23:0] r_c2;

    logic [15:0] r_rem [DIV_STG];
    logic [31:0] r_lo  [DIV_STG];
    logic [31:0] r_q   [DIV_STG];
    logic [23:0] r_cd  [DIV_STG];

    logic [40:0] w_x;
    logic [39:0] r_x;

    assign w_prod = 48'(i_chan) * 48'(i_cfg.gain);

    // 2k - c, squared when positive
    assign w_ds  = 26'({i_cfg.k, 1'b0}) - 26'(r_c1);
    assign w_pos = !w_ds[25] && (w_ds != '0);
    assign w_dsq = w_pos ? 34'(w_ds[16:0]) * 34'(w_ds[16:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1  <= (|w_prod[47:40]) ? 24'hFFFFFF : w_prod[39:16];
            r_dsq <= w_dsq[32:0];
            r_c2  <= r_c1;
        end
    end

    // d^2 * 2^14 / k, two quotient bits per stage
    for (genvar g = 0; g < DIV_STG; g++) begin : g_div
        logic [15:0] w_rin;
        logic [31:0] w_lin;
        logic [31:0] w_qin;
        logic [23:0] w_cin;
        logic [79:0] w_res;
        if (g == 0) begin : g_first
            assign w_rin = {1'b0, r_dsq[32:18]};
            assign w_lin = {r_dsq[17:0], 14'b0};
            assign w_qin = '0;
            assign w_cin = r_c2;
        end else begin : g_rest
            assign w_rin = r_rem[g-1];
            assign w_lin = r_lo[g-1];
            assign w_qin = r_q[g-1];
            assign w_cin = r_cd[g-1];
        end
        assign w_res = toe_step2(w_rin, w_lin, w_qin, i_cfg.k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_res[79:64];
                r_lo[g]  <= w_res[63:32];
                r_q[g]   <= w_res[31:0];
                r_cd[g]  <= w_cin;
            end
        end
    end

    // x = (c - k) in Q32 plus the toe term; never negative
    assign w_x = 41'({r_cd[DIV_STG-1], 16'b0}) + 41'(r_q[DIV_STG-1])
               - 41'({i_cfg.k, 16'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= w_x[39:0];
        end
    end

    assign o_x = r_x;

endmodule

// ----- rtl/ftc_curve.sv -----
// ----------------------------------------------------------------------------
// ftc_curve
// Rational curve (310x^2+25x)/(310x^2+85x+3) with 16 quotient bits.
// ----------------------------------------------------------------------------
module ftc_curve
    import ftc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [39:0] i_x,
    output logic [15:0] o_q
);

    localparam int DIV_STG = CRV_STAGES - 4;

    logic [39:0] r_hh, r_hl, r_ll;
    logic [39:0] r_x1, r_x2;
    logic [79:0] r_sq;
    logic [88:0] w_s310;
    logic [88:0] r_s310;
    logic [44:0] r_x25;
    logic [46:0] r_x85;
    logic [88:0] r_num, r_den;

    logic [88:0] r_rem [DIV_STG];
    logic [88:0] r_dv  [DIV_STG];
    logic [15:0] r_q   [DIV_STG];

    assign w_s310 = (89'(r_sq) << 8) + (89'(r_sq) << 5) + (89'(r_sq) << 4)
                  + (89'(r_sq) << 2) + (89'(r_sq) << 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // 40x40 square from 20-bit halves
            r_hh   <= 40'(i_x[39:20]) * 40'(i_x[39:20]);
            r_hl   <= 40'(i_x[39:20]) * 40'(i_x[19:0]);
            r_ll   <= 40'(i_x[19:0]) * 40'(i_x[19:0]);
            r_x1   <= i_x;
            r_sq   <= (80'(r_hh) << 40) + (80'(r_hl) << 21) + 80'(r_ll);
            r_x2   <= r_x1;
            r_s310 <= w_s310;
            r_x25  <= 45'(r_x2) * 45'd25;
            r_x85  <= 47'(r_x2) * 47'd85;
            r_num  <= r_s310 + (89'(r_x25) << 32);
            r_den  <= r_s310 + (89'(r_x85) << 32) + (89'd3 << 64);
        end
    end

    for (genvar g = 0; g < DIV_STG; g++) begin : g_div
        logic [88:0] w_rin;
        logic [88:0] w_din;
        logic [15:0] w_qin;
        logic [89:0] w_r2;
        logic        w_ge;
        if (g == 0) begin : g_first
            assign w_rin = r_num;
            assign w_din = r_den;
            assign w_qin = '0;
        end else begin : g_rest
            assign w_rin = r_rem[g-1];
            assign w_din = r_dv[g-1];
            assign w_qin = r_q[g-1];
        end
        assign w_r2 = {w_rin, 1'b0};
        assign w_ge = w_r2 >= {1'b0, w_din};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_ge ? 89'(w_r2 - {1'b0, w_din}) : w_r2[88:0];
                r_dv[g]  <= w_din;
                r_q[g]   <= {w_qin[14:0], w_ge};
            end
        end
    end

    assign o_q = r_q[DIV_STG-1];

endmodule

// ----- rtl/ftc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ftc_ctrl
// Stage valid bits and output skid control for the pipeline.
// ----------------------------------------------------------------------------
module ftc_ctrl
    import ftc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_stall,
    output t_ctl o_ctl
);

    logic [NSTG-1:0] r_v;
    logic            r_skid_v;
    logic            w_adv;
    logic            w_load;

    assign w_adv  = !r_skid_v;
    assign w_load = !r_skid_v && r_v[NSTG-1] && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_adv) begin
                r_v <= {r_v[NSTG-2:0], i_valid};
            end
            if (w_load) begin
                r_skid_v <= 1'b1;
            end else if (r_skid_v && !i_stall) begin
                r_skid_v <= 1'b0;
            end
        end
    end

    assign o_ctl.adv       = w_adv;
    assign o_ctl.use_skid  = r_skid_v;
    assign o_ctl.load_skid = w_load;
    assign o_ctl.out_valid = r_skid_v || r_v[NSTG-1];

endmodule

// ----- rtl/filmic_tone_curve_rgb_top.sv -----
// ----------------------------------------------------------------------------
// filmic_tone_curve_rgb_top
// Filmic tone curve for RGB pixels: exposure, black toe, rational curve.
// ----------------------------------------------------------------------------
// One pixel word per clock while o_stall is low. Each HDR channel
// (Q8.16) is scaled by the exposure gain and saturated, blended through
// the black toe with cutoff k (a cutoff of zero acts as one LSB, above one
// half as one half), then mapped through (310x^2+25x)/(310x^2+85x+3) to
// Q0.16. The pipeline has 19 stages for exposure and toe (the toe term
// divides by k at two quotient bits a stage) and 20 for the curve (split
// square, constant scaling, then one quotient bit a stage). A one-word skid
// register at the output lets one more word enter while the result waits;
// after that o_stall holds the whole pipeline. Write config only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module filmic_tone_curve_rgb_top
    import ftc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  t_pix_in     i_data,
    // pixel output channel
    output logic        o_valid,
    input  logic        i_stall,
    output t_pix_out    o_data,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_wdata
);

    logic [23:0] r_exposure_gain;
    logic [15:0] r_toe_cutoff;
    t_cfg        w_cfg;
    t_ctl        w_ctl;
    logic [39:0] w_x [3];
    logic [15:0] w_q [3];
    logic [23:0] w_chan [3];
    t_pix_out    w_out;
    t_pix_out    r_skid;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure_gain <= 24'd65536;
            r_toe_cutoff    <= 16'd1638;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EXPOSURE_GAIN: r_exposure_gain <= i_cfg_wdata;
                CFG_TOE_CUTOFF:    r_toe_cutoff    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // clamp cutoff into its legal range
    always_comb begin
        w_cfg.gain = r_exposure_gain;
        priority if (r_toe_cutoff == '0) begin
            w_cfg.k = K_MIN;
        end else if (r_toe_cutoff > K_MAX) begin
            w_cfg.k = K_MAX;
        end else begin
            w_cfg.k = r_toe_cutoff;
        end
    end

    ftc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_ctl   (w_ctl)
    );

    assign w_chan[0] = i_data.red_in;
    assign w_chan[1] = i_data.green_in;
    assign w_chan[2] = i_data.blue_in;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        ftc_toe u_toe (
            .i_clk  (i_clk),
            .i_en   (w_ctl.adv),
            .i_cfg  (w_cfg),
            .i_chan (w_chan[c]),
            .o_x    (w_x[c])
        );
        ftc_curve u_curve (
            .i_clk (i_clk),
            .i_en  (w_ctl.adv),
            .i_x   (w_x[c]),
            .o_q   (w_q[c])
        );
    end

    assign w_out.red_out   = w_q[0];
    assign w_out.green_out = w_q[1];
    assign w_out.blue_out  = w_q[2];

    // skid word catches the last stage when the consumer stalls
    always_ff @(posedge i_clk) begin
        if (w_ctl.load_skid) begin
            r_skid <= w_out;
        end
    end

    assign o_data  = w_ctl.use_skid ? r_skid : w_out;
    assign o_valid = w_ctl.out_valid;
    assign o_stall = w_ctl.use_skid;

`ifndef ASSERT_OFF
    // input held only while a result is parked in the skid word
    a_stall_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word");

    // a captured skid word is presented next cycle
    a_skid_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load_skid |=> (o_stall && o_valid && o_data == $past(w_out)))
        else $error("skid word lost");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output valid after reset");
`endif

endmodule
